@@ rtl/nhp_pkg.sv @@
// Shared types and constants for the netpbm header parser.
// Depends on nothing; the front, back and top files in rtl refer to it by scoped names.

package nhp_pkg;

    localparam int unsigned VALUE_BITS_DEF  = 16;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_TRUNC    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  type_first;
        logic [7:0]  type_second;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] max_color;
        logic [1:0]  status;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_ws;
        logic       is_hash;
        logic       is_newline;
        logic       first_byte;
        logic       last_byte;
    } t_class;

endpackage

@@ rtl/nhp_fifo.sv @@
// Small register queue used between the parser stages and at the result side.
// Depends on nothing; the beat type and depth come in as parameters.

module nhp_fifo #(
    parameter type         t_data = logic,
    parameter int unsigned DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_data           r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_count;
    logic            wr_en;
    logic            rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10: begin
                n_count = r_count + 1'b1;
            end
            2'b01: begin
                n_count = r_count - 1'b1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/nhp_front.sv @@
// Front stage: takes file bytes, classifies each one and queues it for the engine.
// Depends on nhp_pkg and nhp_fifo.

module nhp_front #(
    parameter int unsigned QUEUE_DEPTH = nhp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nhp_pkg::t_in_beat i_beat,
    output logic              o_full,
    input  logic              i_pop,
    output nhp_pkg::t_class   o_item,
    output logic              o_empty
);

    nhp_pkg::t_class cls;
    logic [7:0]      b;

    assign b = i_beat.data_byte;

    always_comb begin
        cls.data_byte  = b;
        cls.digit      = b[3:0];
        cls.is_digit   = (b >= nhp_pkg::CHAR_ZERO) && (b <= nhp_pkg::CHAR_NINE);
        cls.is_ws      = (b == nhp_pkg::CHAR_SPACE)
                         || ((b >= nhp_pkg::CHAR_TAB) && (b <= nhp_pkg::CHAR_CR));
        cls.is_hash    = (b == nhp_pkg::CHAR_HASH);
        cls.is_newline = (b == nhp_pkg::CHAR_NEWLINE);
        cls.first_byte = i_beat.first_byte;
        cls.last_byte  = i_beat.last_byte;
    end

    nhp_fifo #(
        .t_data (nhp_pkg::t_class),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_item),
        .o_empty (o_empty)
    );

endmodule

@@ rtl/nhp_back.sv @@
// Back stage: the header parsing engine, one classified byte per clock while the result queue is not full.
// Depends on nhp_pkg; feeds the result queue in the top level.

module nhp_back #(
    parameter int unsigned VALUE_BITS = nhp_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nhp_pkg::t_class    i_item,
    input  logic               i_item_valid,
    output logic               o_item_take,
    input  logic               i_res_full,
    output logic               o_res_push,
    output nhp_pkg::t_out_beat o_res
);

    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_SKIP_W = 3'd1;
    localparam logic [2:0] PH_WIDTH  = 3'd2;
    localparam logic [2:0] PH_SKIP_H = 3'd3;
    localparam logic [2:0] PH_HEIGHT = 3'd4;
    localparam logic [2:0] PH_SKIP_M = 3'd5;
    localparam logic [2:0] PH_MAX    = 3'd6;

    localparam int unsigned SW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] LIMIT = {VALUE_BITS{1'b1}};

    logic [2:0]            r_phase;
    logic                  r_in_comment;
    logic [7:0]            r_type0;
    logic [7:0]            r_type1;
    logic [1:0]            r_type_count;
    logic [VALUE_BITS-1:0] r_width;
    logic [VALUE_BITS-1:0] r_height;
    logic [VALUE_BITS-1:0] r_accum;
    logic                  r_overflow;
    logic                  r_done;

    logic [2:0]            n_phase;
    logic                  n_in_comment;
    logic [7:0]            n_type0;
    logic [7:0]            n_type1;
    logic [1:0]            n_type_count;
    logic [VALUE_BITS-1:0] n_width;
    logic [VALUE_BITS-1:0] n_height;
    logic [VALUE_BITS-1:0] n_accum;
    logic                  n_overflow;
    logic                  n_done;

    logic [VALUE_BITS-1:0] acc_base;
    logic [SW-1:0]         acc_sum;
    logic                  acc_sat;
    logic [VALUE_BITS-1:0] acc_next;
    logic                  emit;
    logic                  go;

    assign go          = i_item_valid && !i_res_full;
    assign o_item_take = go;
    assign o_res_push  = go && emit;

    always_comb begin
        n_phase      = r_phase;
        n_in_comment = r_in_comment;
        n_type0      = r_type0;
        n_type1      = r_type1;
        n_type_count = r_type_count;
        n_width      = r_width;
        n_height     = r_height;
        n_accum      = r_accum;
        n_overflow   = r_overflow;
        n_done       = r_done;
        emit         = 1'b0;
        o_res        = '0;

        if (i_item.first_byte) begin
            n_phase      = PH_TYPE;
            n_in_comment = 1'b0;
            n_type0      = '0;
            n_type1      = '0;
            n_type_count = '0;
            n_width      = '0;
            n_height     = '0;
            n_accum      = '0;
            n_overflow   = 1'b0;
            n_done       = 1'b0;
        end

        acc_base = ((n_phase == PH_WIDTH) || (n_phase == PH_HEIGHT) || (n_phase == PH_MAX))
                   ? n_accum : '0;
        acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                   + SW'(i_item.digit);
        acc_sat  = |acc_sum[SW-1:VALUE_BITS];
        acc_next = acc_sat ? LIMIT : acc_sum[VALUE_BITS-1:0];

        if (!n_done) begin
            unique case (n_phase)
                PH_TYPE: begin
                    if (i_item.is_ws) begin
                        if (n_type_count != '0) begin
                            n_phase = PH_SKIP_W;
                        end
                    end else begin
                        if (n_type_count[0]) begin
                            n_type1 = i_item.data_byte;
                            n_phase = PH_SKIP_W;
                        end else begin
                            n_type0 = i_item.data_byte;
                        end
                        n_type_count = n_type_count + 1'b1;
                    end
                end
                PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
                    if (n_in_comment) begin
                        if (i_item.is_newline) begin
                            n_in_comment = 1'b0;
                        end
                    end else if (i_item.is_hash) begin
                        n_in_comment = 1'b1;
                    end else if (i_item.is_digit) begin
                        n_accum    = acc_next;
                        n_overflow = n_overflow | acc_sat;
                        n_phase    = n_phase + 1'b1;
                    end
                end
                PH_WIDTH, PH_HEIGHT: begin
                    if (i_item.is_digit) begin
                        n_accum    = acc_next;
                        n_overflow = n_overflow | acc_sat;
                    end else begin
                        if (n_phase == PH_WIDTH) begin
                            n_width = n_accum;
                        end else begin
                            n_height = n_accum;
                        end
                        n_phase      = n_phase + 1'b1;
                        n_in_comment = i_item.is_hash;
                    end
                end
                PH_MAX: begin
                    if (i_item.is_digit) begin
                        n_accum    = acc_next;
                        n_overflow = n_overflow | acc_sat;
                    end else begin
                        emit            = 1'b1;
                        o_res.max_color = 16'(n_accum);
                        o_res.status    = n_overflow ? nhp_pkg::ST_OVERFLOW
                                                     : nhp_pkg::ST_DONE;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (!emit && i_item.last_byte) begin
                emit = 1'b1;
                if (n_phase == PH_MAX) begin
                    o_res.max_color = 16'(n_accum);
                    o_res.status    = n_overflow ? nhp_pkg::ST_OVERFLOW
                                                 : nhp_pkg::ST_DONE;
                end else begin
                    o_res.max_color = '0;
                    o_res.status    = nhp_pkg::ST_TRUNC;
                end
            end

            if (emit) begin
                n_done = 1'b1;
            end
        end

        o_res.type_first   = n_type0;
        o_res.type_second  = n_type1;
        o_res.image_width  = 16'(n_width);
        o_res.image_height = 16'(n_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TYPE;
            r_in_comment <= 1'b0;
            r_type0      <= '0;
            r_type1      <= '0;
            r_type_count <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_accum      <= '0;
            r_overflow   <= 1'b0;
            r_done       <= 1'b0;
        end else if (go) begin
            r_phase      <= n_phase;
            r_in_comment <= n_in_comment;
            r_type0      <= n_type0;
            r_type1      <= n_type1;
            r_type_count <= n_type_count;
            r_width      <= n_width;
            r_height     <= n_height;
            r_accum      <= n_accum;
            r_overflow   <= n_overflow;
            r_done       <= n_done;
        end
    end

endmodule

@@ rtl/netpbm_header_parser.sv @@
// Top level of the netpbm header parser: byte queue, parsing engine, result queue.
// Depends on nhp_pkg, nhp_front, nhp_back and nhp_fifo.

// The parser takes one file byte per clock and sustains that rate as long as
// results are popped. A byte first enters a classifier and a short input queue;
// the parsing engine takes one byte from that queue per clock and writes any
// header result into a result queue of the same depth. A result is therefore
// visible only after its final byte has passed the input queue and the result queue.
// The engine stalls only while the result queue is full, and full rises once
// the input queue holds QUEUE_DEPTH bytes. Each value is accumulated with one
// multiply by ten and add per byte, saturating at 2^VALUE_BITS - 1.
module netpbm_header_parser #(
    parameter int unsigned VALUE_BITS  = nhp_pkg::VALUE_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = nhp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  nhp_pkg::t_in_beat  i_in_beat,
    output logic               empty,
    input  logic               pop,
    output nhp_pkg::t_out_beat o_out_beat
);

    nhp_pkg::t_class    mid_item;
    logic               mid_empty;
    logic               mid_take;
    logic               res_full;
    logic               res_push;
    nhp_pkg::t_out_beat res_beat;

    nhp_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (i_in_beat),
        .o_full  (full),
        .i_pop   (mid_take),
        .o_item  (mid_item),
        .o_empty (mid_empty)
    );

    nhp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (mid_item),
        .i_item_valid (!mid_empty),
        .o_item_take  (mid_take),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_beat)
    );

    nhp_fifo #(
        .t_data (nhp_pkg::t_out_beat),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_beat),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out_beat),
        .o_empty (empty)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_take |-> !mid_empty)
        else $error("engine took a byte from an empty input queue");

    a_trunc_no_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_beat.status == nhp_pkg::ST_TRUNC)) |-> (o_out_beat.max_color == '0))
        else $error("truncated header reports a maximum color value");
`endif

endmodule

@@ tb/sv/tb_netpbm_header_parser.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for netpbm_header_parser: a directed byte table, then random files.
// Depends on nhp_pkg and the parser RTL; the directed table and a byte-level predictor supply the expected headers.

module tb_netpbm_header_parser;

    import nhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned BYTE_TARGET  = 900;
    localparam int unsigned QUIET_FROM   = 780;
    localparam int unsigned HOLD_FROM    = 300;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned DIRECTED_LEN = 28;

    localparam t_out_beat NO_HEADER = '0;

    typedef enum logic [2:0] {
        SCAN_MAGIC, SCAN_GAP_W, SCAN_WIDTH, SCAN_GAP_H, SCAN_HEIGHT, SCAN_GAP_M, SCAN_MAXVAL
    } scan_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       typed;
        t_out_beat  res;
    } dir_row_t;

    typedef struct packed {
        logic      typed;
        t_out_beat res;
    } pending_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_beat  i_in_beat;
    logic      empty;
    logic      pop;
    t_out_beat o_out_beat;

    netpbm_header_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_beat  (i_in_beat),
        .empty      (empty),
        .pop        (pop),
        .o_out_beat (o_out_beat)
    );

    scan_phase_e scan_phase;
    logic        in_remark;
    logic [7:0]  magic_chars [2];
    logic [1:0]  magic_count;
    logic [15:0] width_val;
    logic [15:0] height_val;
    logic [15:0] value_accum;
    logic        value_clipped;
    logic        header_sent;

    t_out_beat   expected_headers [$];
    pending_t    pending_rows [$];
    t_in_beat    file_q [$];
    dir_row_t    directed_rows [DIRECTED_LEN];

    int unsigned error_count;
    int unsigned cycle_count;
    bit          quiet;
    bit          hold_req;
    bit          hold_taken;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic bit is_ws(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void clear_header_state();
        scan_phase     = SCAN_MAGIC;
        in_remark      = 1'b0;
        magic_chars[0] = '0;
        magic_chars[1] = '0;
        magic_count    = '0;
        width_val      = '0;
        height_val     = '0;
        value_accum    = '0;
        value_clipped  = 1'b0;
        header_sent    = 1'b0;
    endfunction

    function automatic void take_digit(logic [7:0] c);
        logic [19:0] v;
        v = value_accum * 20'd10 + 20'(c - CHAR_ZERO);
        if (v > 20'd65535) begin
            v = 20'd65535;
            value_clipped = 1'b1;
        end
        value_accum = v[15:0];
    endfunction

    function automatic t_out_beat finish_header(logic [15:0] maxc, logic [1:0] st);
        t_out_beat r;
        r.type_first   = magic_chars[0];
        r.type_second  = magic_chars[1];
        r.image_width  = width_val;
        r.image_height = height_val;
        r.max_color    = maxc;
        r.status       = st;
        header_sent    = 1'b1;
        return r;
    endfunction

    function automatic bit scan_byte(input t_in_beat b, output t_out_beat r);
        logic [7:0] c;
        c = b.data_byte;
        r = NO_HEADER;
        if (b.first_byte)
            clear_header_state();
        if (header_sent)
            return 1'b0;
        case (scan_phase)
            SCAN_MAGIC: begin
                if (is_ws(c)) begin
                    if (magic_count != 0)
                        scan_phase = SCAN_GAP_W;
                end else begin
                    magic_chars[magic_count[0]] = c;
                    magic_count = magic_count + 2'd1;
                    if (magic_count >= 2)
                        scan_phase = SCAN_GAP_W;
                end
            end
            SCAN_GAP_W, SCAN_GAP_H, SCAN_GAP_M: begin
                if (in_remark) begin
                    if (c == CHAR_NEWLINE)
                        in_remark = 1'b0;
                end else if (c == CHAR_HASH) begin
                    in_remark = 1'b1;
                end else if (is_digit(c)) begin
                    value_accum = '0;
                    take_digit(c);
                    scan_phase = scan_phase_e'(scan_phase + 3'd1);
                end
            end
            SCAN_WIDTH, SCAN_HEIGHT: begin
                if (is_digit(c)) begin
                    take_digit(c);
                end else begin
                    if (scan_phase == SCAN_WIDTH)
                        width_val = value_accum;
                    else
                        height_val = value_accum;
                    scan_phase = scan_phase_e'(scan_phase + 3'd1);
                    in_remark = (c == CHAR_HASH);
                end
            end
            default: begin
                if (is_digit(c)) begin
                    take_digit(c);
                end else begin
                    r = finish_header(value_accum, value_clipped ? ST_OVERFLOW : ST_DONE);
                    return 1'b1;
                end
            end
        endcase
        if (b.last_byte) begin
            if (scan_phase == SCAN_MAXVAL)
                r = finish_header(value_accum, value_clipped ? ST_OVERFLOW : ST_DONE);
            else
                r = finish_header(16'd0, ST_TRUNC);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic string show_header(t_out_beat h);
        return $sformatf("type=%h/%h w=%0d h=%0d max=%0d status=%0d", h.type_first,
                         h.type_second, h.image_width, h.image_height, h.max_color, h.status);
    endfunction

    task automatic flag_error(string what, t_out_beat want, t_out_beat got);
        error_count++;
        if (error_count <= 10)
            $display("ERROR %s at %0t: expected %s, got %s", what, $realtime,
                     show_header(want), show_header(got));
    endtask

    function automatic logic [7:0] pick_byte(bit no_digit, bit no_ws, bit no_nl, bit no_hash);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((no_digit && is_digit(c)) || (no_ws && is_ws(c)) ||
               (no_nl && c == CHAR_NEWLINE) || (no_hash && c == CHAR_HASH));
        return c;
    endfunction

    function automatic logic [7:0] pick_ws();
        if ($urandom_range(0, 2) != 0)
            return CHAR_SPACE;
        return CHAR_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic void put(logic [7:0] c);
        file_q.push_back('{data_byte: c, first_byte: 1'b0, last_byte: 1'b0});
    endfunction

    function automatic void put_gap();
        int unsigned pieces;
        int unsigned n;
        pieces = $urandom_range(1, 2);
        repeat (pieces) begin
            case ($urandom_range(0, 5))
                4: begin
                    put(CHAR_HASH);
                    n = $urandom_range(0, 3);
                    repeat (n) put(pick_byte(1'b0, 1'b0, 1'b1, 1'b0));
                    put(CHAR_NEWLINE);
                end
                5: put(pick_byte(1'b1, 1'b0, 1'b0, 1'b1));
                default: put(pick_ws());
            endcase
        end
    endfunction

    function automatic void put_number();
        int unsigned ndig;
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (ndig) put(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void build_file();
        int unsigned n;
        int unsigned cut;
        file_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) put(8'($urandom_range(0, 255)));
            file_q[file_q.size() - 1].last_byte = 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 2);
                repeat (n) put(pick_ws());
            end
            case ($urandom_range(0, 7))
                6: begin
                    put(pick_byte(1'b0, 1'b1, 1'b0, 1'b0));
                    put(pick_ws());
                end
                7: begin
                    put(CHAR_HASH);
                    put(pick_byte(1'b0, 1'b1, 1'b0, 1'b0));
                end
                default: begin
                    put("P");
                    put("1" + 8'($urandom_range(0, 6)));
                end
            endcase
            if ($urandom_range(0, 5) != 0)
                put_gap();
            put_number();
            put_gap();
            put_number();
            put_gap();
            put_number();
            case ($urandom_range(0, 7))
                0: file_q[file_q.size() - 1].last_byte = 1'b1;
                1: put(pick_byte(1'b1, 1'b0, 1'b0, 1'b0));
                default: put(pick_ws());
            endcase
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(0, file_q.size() - 1);
                while (file_q.size() > cut + 1)
                    void'(file_q.pop_back());
                file_q[cut].last_byte = 1'b1;
            end
        end
        file_q[0].first_byte = ($urandom_range(0, 19) != 0);
    endfunction

    task automatic offer(input t_in_beat b, input bit typed, input t_out_beat res,
                         input bit may_idle);
        pending_rows.push_back('{typed: typed, res: res});
        push      <= 1'b1;
        i_in_beat <= b;
        do
            @(posedge i_clk);
        while (full);
        if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        pending_t  row;
        t_out_beat want;
        t_out_beat predicted;
        bit        made;
        if (i_rst_n) begin
            if (push && !full) begin
                row  = pending_rows.pop_front();
                made = scan_byte(i_in_beat, predicted);
                if (row.typed)
                    expected_headers.push_back(row.res);
                else if (made)
                    expected_headers.push_back(predicted);
            end
            if (pop && !empty) begin
                if (expected_headers.size() == 0) begin
                    flag_error("unexpected header", NO_HEADER, o_out_beat);
                end else begin
                    want = expected_headers.pop_front();
                    if (o_out_beat.type_first   !== want.type_first   ||
                        o_out_beat.type_second  !== want.type_second  ||
                        o_out_beat.image_width  !== want.image_width  ||
                        o_out_beat.image_height !== want.image_height ||
                        o_out_beat.max_color    !== want.max_color    ||
                        o_out_beat.status       !== want.status)
                        flag_error("header differs", want, o_out_beat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("netpbm_header_parser: mismatch");
            $finish;
        end
    end

    initial begin
        pop <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned counted;
        int unsigned n;
        bit          hold_sent;
        t_in_beat    b;

        error_count = 0;
        cycle_count = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        hold_taken  = 1'b0;
        hold_sent   = 1'b0;
        sent        = 0;
        clear_header_state();

        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_in_beat <= '0;

        directed_rows = '{
            '{8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, 8'h00, 16'd0, 16'd0, 16'd0, ST_TRUNC}},
            '{8'h00, 1'b1, 1'b1, 1'b1, '{8'h00, 8'h00, 16'd0, 16'd0, 16'd0, ST_TRUNC}},
            '{"P",          1'b1, 1'b0, 1'b0, NO_HEADER},
            '{"4",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_HASH,    1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"x",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_NEWLINE, 1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_SPACE,   1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"9",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_SPACE,   1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"7",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_NEWLINE, 1'b0, 1'b0, 1'b1,
              '{"P", "4", 16'd9, 16'd65535, 16'd7, ST_OVERFLOW}},
            '{"Z",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"P",          1'b1, 1'b0, 1'b0, NO_HEADER},
            '{"5",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"0",          1'b0, 1'b1, 1'b1, '{"P", "5", 16'd0, 16'd0, 16'd0, ST_TRUNC}},
            '{CHAR_HASH,    1'b1, 1'b0, 1'b0, NO_HEADER},
            '{"6",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"1",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_SPACE,   1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"2",          1'b0, 1'b0, 1'b0, NO_HEADER},
            '{CHAR_SPACE,   1'b0, 1'b0, 1'b0, NO_HEADER},
            '{"3",          1'b0, 1'b1, 1'b1, '{CHAR_HASH, "6", 16'd1, 16'd2, 16'd3, ST_DONE}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            b = '{data_byte: directed_rows[i].data, first_byte: directed_rows[i].first,
                  last_byte: directed_rows[i].last};
            offer(b, directed_rows[i].typed, directed_rows[i].res, 1'b1);
        end

        while (sent < BYTE_TARGET) begin
            if (!hold_sent && sent >= HOLD_FROM) begin
                hold_sent = 1'b1;
                hold_req  = 1'b1;
                repeat (30) begin
                    b = '{data_byte: 8'($urandom_range(0, 255)), first_byte: 1'b1,
                          last_byte: 1'b1};
                    offer(b, 1'b0, NO_HEADER, 1'b0);
                end
                sent += 30;
            end
            build_file();
            counted = file_q.size();
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 3);
                repeat (n) put(8'($urandom_range(0, 255)));
            end
            foreach (file_q[i])
                offer(file_q[i], 1'b0, NO_HEADER, 1'b1);
            sent += counted;
            if (sent >= QUIET_FROM)
                quiet = 1'b1;
        end
        push <= 1'b0;

        while (pending_rows.size() != 0 || expected_headers.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("netpbm_header_parser: match");
        else
            $display("netpbm_header_parser: mismatch");
        $finish;
    end

endmodule

@@ netpbm_header_parser.f @@
rtl/nhp_pkg.sv
rtl/nhp_fifo.sv
rtl/nhp_front.sv
rtl/nhp_back.sv
rtl/netpbm_header_parser.sv
tb/sv/tb_netpbm_header_parser.sv
